FILE: rtl/jsns_pkg.sv
// ----------------------------------------------------------------------------
// jsns_pkg
// shared types, widths and command codes of the joint state neighbor store
// ----------------------------------------------------------------------------
package jsns_pkg;

    localparam int JOINT_W         = 16;
    localparam int JOINT_SLOTS     = 7;
    localparam int DIST_W          = 34;
    localparam int NODE_W          = 6;
    localparam int CMD_W           = 2;
    localparam int RESULT_CAP      = 64;
    localparam int CAP_W           = 7;
    localparam int MAX_ENTRIES_DEF = 64;
    localparam int JOINT_COUNT_DEF = 7;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND    = 2'd0,
        CMD_NEAREST   = 2'd1,
        CMD_NEIGHBORS = 2'd2
    } cmd_e;

    // token moving down the cell chain
    typedef struct packed {
        logic valid;
        logic fin;
    } tok_t;

endpackage

FILE: rtl/jsns_ram.sv
// ----------------------------------------------------------------------------
// jsns_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module jsns_ram #(
    parameter int WIDTH = 112,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/jsns_cell.sv
// ----------------------------------------------------------------------------
// jsns_cell
// one joint of the distance chain: adds the squared joint difference to the
// partial sum from the previous cell and hands it on
// ----------------------------------------------------------------------------
module jsns_cell #(
    parameter int IDX_W     = 6,
    parameter int ROW_W     = 112,
    parameter int JOINT_SEL = 0
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  jsns_pkg::tok_t              in_tok,
    input  logic [IDX_W-1:0]            in_idx,
    input  logic [ROW_W-1:0]            in_row,
    input  logic [jsns_pkg::DIST_W-1:0] in_sum,
    input  logic [ROW_W-1:0]            query,
    output jsns_pkg::tok_t              out_tok_reg,
    output logic [IDX_W-1:0]            out_idx_reg,
    output logic [ROW_W-1:0]            out_row_reg,
    output logic [jsns_pkg::DIST_W-1:0] out_sum_reg
);

    logic [jsns_pkg::JOINT_W-1:0]   a_j;
    logic [jsns_pkg::JOINT_W-1:0]   b_j;
    logic [jsns_pkg::JOINT_W:0]     diff;
    logic [jsns_pkg::JOINT_W:0]     neg;
    logic [jsns_pkg::JOINT_W-1:0]   mag;
    logic [2*jsns_pkg::JOINT_W-1:0] sq;
    logic [jsns_pkg::DIST_W:0]      sum_wide;
    logic [jsns_pkg::DIST_W-1:0]    sum_next;

    assign a_j      = in_row[JOINT_SEL*jsns_pkg::JOINT_W +: jsns_pkg::JOINT_W];
    assign b_j      = query[JOINT_SEL*jsns_pkg::JOINT_W +: jsns_pkg::JOINT_W];
    assign diff     = {a_j[jsns_pkg::JOINT_W-1], a_j} - {b_j[jsns_pkg::JOINT_W-1], b_j};
    assign neg      = -diff;
    assign mag      = diff[jsns_pkg::JOINT_W] ? neg[jsns_pkg::JOINT_W-1:0]
                                               : diff[jsns_pkg::JOINT_W-1:0];
    assign sq       = mag * mag;
    assign sum_wide = {1'b0, in_sum}
                    + {{(jsns_pkg::DIST_W + 1 - 2*jsns_pkg::JOINT_W){1'b0}}, sq};
    assign sum_next = sum_wide[jsns_pkg::DIST_W] ? jsns_pkg::DIST_MAX
                                                 : sum_wide[jsns_pkg::DIST_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_tok_reg <= '0;
        end else if (adv) begin
            out_tok_reg <= in_tok;
        end
        if (adv) begin
            out_idx_reg <= in_idx;
            out_row_reg <= in_row;
            out_sum_reg <= sum_next;
        end
    end

endmodule

FILE: rtl/joint_state_neighbor_store.sv
// ----------------------------------------------------------------------------
// joint_state_neighbor_store
// store of joint states answering append, nearest and neighbor list commands
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries commands (command code in s_tuser), m_ channel carries
//   results, cfg_wr_en and cfg_wr_data write the squared neighbor threshold;
//   the user must write it only while the block is idle, the block does not enforce it.
//   append registers its result through the ST_DIRECT state.
//   nearest and neighbor list read the stored entries from the ram one per
//   cycle, unless the receiver stalls, through a chain of JOINT_COUNT
//   distance cells; neighbor list with a valid entry index first fetches
//   the chosen entry in ST_LOAD and ST_REF. neighbor results stream out in
//   index order, the last one marked by m_tlast.
//   one command is in work at a time; s_tready is high only while idle.
//   when the receiver stalls, the result register holds and the whole scan
//   chain freezes until it is taken, so nothing is lost.
//   reset empties the store and clears the threshold; there is no clearing
//   pass, entries beyond the fill count never reach a result.
// ----------------------------------------------------------------------------
module joint_state_neighbor_store #(
    parameter int MAX_ENTRIES = jsns_pkg::MAX_ENTRIES_DEF,
    parameter int JOINT_COUNT = jsns_pkg::JOINT_COUNT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [jsns_pkg::DIST_W-1:0] cfg_wr_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // entry_index, joint_a .. joint_g
    input  logic [119:0]                s_tdata,
    // cmd
    input  logic [jsns_pkg::CMD_W-1:0]  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // node_index, distance_squared
    output logic [39:0]                 m_tdata,
    // found, overflow
    output logic [1:0]                  m_tuser,
    output logic                        m_tlast
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int ROW_W = JOINT_COUNT * jsns_pkg::JOINT_W;
    localparam int EXT_W = IDX_W + jsns_pkg::NODE_W;
    localparam int IN_JOINT_LSB = jsns_pkg::NODE_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_REF,
        ST_SCAN,
        ST_DRAIN,
        ST_DIRECT
    } state_t;

    state_t                      state_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            scan_reg;
    logic [jsns_pkg::DIST_W-1:0] thr_reg;
    logic [jsns_pkg::CMD_W-1:0]  cmd_reg;
    logic [IDX_W-1:0]            e_reg;
    logic [ROW_W-1:0]            query_reg;
    logic                        best_v_reg;
    logic [IDX_W-1:0]            best_idx_reg;
    logic [jsns_pkg::DIST_W-1:0] best_d_reg;
    logic                        pend_v_reg;
    logic [IDX_W-1:0]            pend_idx_reg;
    logic [jsns_pkg::DIST_W-1:0] pend_d_reg;
    logic [jsns_pkg::CAP_W-1:0]  nb_cnt_reg;
    logic [IDX_W-1:0]            dir_idx_reg;
    logic                        dir_found_reg;
    logic                        dir_ovf_reg;
    jsns_pkg::tok_t              rd_tok_reg;
    logic [IDX_W-1:0]            rd_idx_reg;
    logic                        m_tvalid_reg;
    logic [jsns_pkg::NODE_W-1:0] m_idx_reg;
    logic [jsns_pkg::DIST_W-1:0] m_dist_reg;
    logic                        m_found_reg;
    logic                        m_ovf_reg;
    logic                        m_last_reg;

    logic                        adv;
    logic                        accept;
    logic [jsns_pkg::CMD_W-1:0]  in_cmd;
    logic [EXT_W-1:0]            in_e_ext;
    logic [EXT_W-1:0]            count_ext;
    logic                        e_ok;
    logic [ROW_W-1:0]            in_row;
    logic                        full;
    jsns_pkg::tok_t              issue_tok;
    logic [IDX_W-1:0]            raddr;
    logic [ROW_W-1:0]            rdata;
    logic                        ram_we;

    jsns_pkg::tok_t              tok_w [JOINT_COUNT+1];
    logic [IDX_W-1:0]            idx_w [JOINT_COUNT+1];
    logic [ROW_W-1:0]            row_w [JOINT_COUNT+1];
    logic [jsns_pkg::DIST_W-1:0] sum_w [JOINT_COUNT+1];

    jsns_pkg::tok_t              t_tok;
    logic [IDX_W-1:0]            t_idx;
    logic [jsns_pkg::DIST_W-1:0] t_sum;
    logic                        hit;
    logic                        t_step;
    logic                        emit_v;
    logic [IDX_W-1:0]            emit_idx;
    logic [jsns_pkg::DIST_W-1:0] emit_d;
    logic                        emit_found;
    logic                        emit_ovf;
    logic                        emit_last;
    logic [EXT_W-1:0]            emit_ext;

    assign adv       = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign in_cmd    = s_tuser;
    assign in_e_ext  = {{IDX_W{1'b0}}, s_tdata[jsns_pkg::NODE_W-1:0]};
    assign count_ext = {{(EXT_W - CNT_W){1'b0}}, count_reg};
    assign e_ok      = in_e_ext < count_ext;
    assign in_row    = s_tdata[IN_JOINT_LSB +: ROW_W];
    assign full      = (count_reg == CNT_W'(MAX_ENTRIES));
    assign ram_we    = accept && (in_cmd == jsns_pkg::CMD_APPEND) && !full;

    always_comb begin
        issue_tok = '0;
        if (state_reg == ST_SCAN) begin
            issue_tok.valid = 1'b1;
            issue_tok.fin   = (scan_reg == count_reg);
        end
    end

    assign raddr = (state_reg == ST_LOAD) ? e_reg : scan_reg[IDX_W-1:0];

    jsns_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (in_row),
        .re    (adv),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign tok_w[0] = rd_tok_reg;
    assign idx_w[0] = rd_idx_reg;
    assign row_w[0] = rdata;
    assign sum_w[0] = '0;

    for (genvar k = 0; k < JOINT_COUNT; k++) begin : g_cell
        jsns_cell #(
            .IDX_W     (IDX_W),
            .ROW_W     (ROW_W),
            .JOINT_SEL (k)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .adv         (adv),
            .in_tok      (tok_w[k]),
            .in_idx      (idx_w[k]),
            .in_row      (row_w[k]),
            .in_sum      (sum_w[k]),
            .query       (query_reg),
            .out_tok_reg (tok_w[k+1]),
            .out_idx_reg (idx_w[k+1]),
            .out_row_reg (row_w[k+1]),
            .out_sum_reg (sum_w[k+1])
        );
    end

    assign t_tok  = tok_w[JOINT_COUNT];
    assign t_idx  = idx_w[JOINT_COUNT];
    assign t_sum  = sum_w[JOINT_COUNT];
    assign t_step = adv && t_tok.valid;
    assign hit    = (t_idx != e_reg) && (t_sum <= thr_reg)
                 && (nb_cnt_reg < jsns_pkg::CAP_W'(jsns_pkg::RESULT_CAP));

    always_comb begin
        emit_v     = 1'b0;
        emit_idx   = '0;
        emit_d     = '0;
        emit_found = 1'b0;
        emit_ovf   = 1'b0;
        emit_last  = 1'b1;
        if (state_reg == ST_DIRECT && adv) begin
            emit_v     = 1'b1;
            emit_idx   = dir_idx_reg;
            emit_found = dir_found_reg;
            emit_ovf   = dir_ovf_reg;
        end else if (t_step && t_tok.fin) begin
            emit_v = 1'b1;
            if (cmd_reg == jsns_pkg::CMD_NEAREST) begin
                emit_idx   = best_v_reg ? best_idx_reg : '0;
                emit_d     = best_v_reg ? best_d_reg : '0;
                emit_found = best_v_reg;
            end else if (pend_v_reg) begin
                emit_idx   = pend_idx_reg;
                emit_d     = pend_d_reg;
                emit_found = 1'b1;
            end
        end else if (t_step && cmd_reg == jsns_pkg::CMD_NEIGHBORS && hit && pend_v_reg) begin
            emit_v     = 1'b1;
            emit_idx   = pend_idx_reg;
            emit_d     = pend_d_reg;
            emit_found = 1'b1;
            emit_last  = 1'b0;
        end
    end

    assign emit_ext = {{jsns_pkg::NODE_W{1'b0}}, emit_idx};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            thr_reg      <= '0;
            rd_tok_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            best_v_reg   <= 1'b0;
            pend_v_reg   <= 1'b0;
            nb_cnt_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            if (adv) begin
                rd_tok_reg <= issue_tok;
                rd_idx_reg <= scan_reg[IDX_W-1:0];
            end
            if (emit_v) begin
                m_tvalid_reg <= 1'b1;
                m_idx_reg    <= emit_ext[jsns_pkg::NODE_W-1:0];
                m_dist_reg   <= emit_d;
                m_found_reg  <= emit_found;
                m_ovf_reg    <= emit_ovf;
                m_last_reg   <= emit_last;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (t_step && !t_tok.fin) begin
                if (cmd_reg == jsns_pkg::CMD_NEAREST) begin
                    if (!best_v_reg || t_sum < best_d_reg) begin
                        best_v_reg   <= 1'b1;
                        best_idx_reg <= t_idx;
                        best_d_reg   <= t_sum;
                    end
                end else if (hit) begin
                    pend_v_reg   <= 1'b1;
                    pend_idx_reg <= t_idx;
                    pend_d_reg   <= t_sum;
                    nb_cnt_reg   <= nb_cnt_reg + 1'b1;
                end
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        cmd_reg    <= in_cmd;
                        best_v_reg <= 1'b0;
                        pend_v_reg <= 1'b0;
                        nb_cnt_reg <= '0;
                        scan_reg   <= '0;
                        query_reg  <= in_row;
                        e_reg      <= in_e_ext[IDX_W-1:0];
                        case (in_cmd)
                            jsns_pkg::CMD_APPEND: begin
                                dir_idx_reg   <= full ? '0 : count_reg[IDX_W-1:0];
                                dir_found_reg <= !full;
                                dir_ovf_reg   <= full;
                                if (!full) begin
                                    count_reg <= count_reg + 1'b1;
                                end
                                state_reg <= ST_DIRECT;
                            end
                            jsns_pkg::CMD_NEAREST: begin
                                state_reg <= ST_SCAN;
                            end
                            jsns_pkg::CMD_NEIGHBORS: begin
                                if (e_ok) begin
                                    state_reg <= ST_LOAD;
                                end else begin
                                    scan_reg  <= count_reg;
                                    state_reg <= ST_SCAN;
                                end
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_LOAD: begin
                    if (adv) begin
                        state_reg <= ST_REF;
                    end
                end
                ST_REF: begin
                    query_reg <= rdata;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (adv) begin
                        if (issue_tok.fin) begin
                            state_reg <= ST_DRAIN;
                        end else begin
                            scan_reg <= scan_reg + 1'b1;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (t_step && t_tok.fin) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DIRECT: begin
                    if (adv) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_dist_reg, m_idx_reg};
    assign m_tuser  = {m_ovf_reg, m_found_reg};
    assign m_tlast  = m_last_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond store depth");

    a_idle_chain_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !t_tok.valid && !rd_tok_reg.valid)
        else $error("scan token left in chain while idle");

    a_cap_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nb_cnt_reg <= jsns_pkg::CAP_W'(jsns_pkg::RESULT_CAP))
        else $error("neighbor count beyond result cap");

    a_ovf_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_ovf_reg |-> !m_found_reg && m_last_reg)
        else $error("overflow result marked found or not last");

    a_append_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> count_reg == $past(count_reg) + 1'b1)
        else $error("append did not advance entry count");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the joint state neighbor store: a directed table of
// appends, nearest queries and neighbor lists, then random traffic with random
// idling on both channels, every result checked against a behavioral model
// ----------------------------------------------------------------------------
module tb;

    localparam int DEPTH = 64;
    localparam int CMD_UNDEF = 3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [5:0]        entry_index;
        logic [6:0][15:0]  joints;
    } cmd_item_t;

    typedef struct {
        logic [5:0]  node;
        logic [33:0] dsq;
        logic        found;
        logic        ovf;
        logic        last;
    } result_t;

    typedef struct {
        cmd_item_t   item;
        logic        known;
        result_t     res;
    } table_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [33:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [119:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0] m_tuser;
    logic m_tlast;

    logic signed [15:0] stored_joints [DEPTH][7];
    int unsigned stored_count;
    logic [33:0] neighbor_limit;
    result_t pending_results[$];
    int errors = 0;
    bit hold_off = 1'b0;
    bit calm_rx = 1'b0;

    joint_state_neighbor_store dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [33:0] joint_distance(logic signed [15:0] p [7],
                                                   logic signed [15:0] q [7]);
        longint sum;
        longint d;
        sum = 0;
        for (int j = 0; j < 7; j++) begin
            d = longint'(p[j]) - longint'(q[j]);
            sum += d * d;
        end
        if (sum > 64'h3_FFFF_FFFF) sum = 64'h3_FFFF_FFFF;
        return sum[33:0];
    endfunction

    function automatic result_t mk(int node, logic [33:0] dsq, bit f, bit o, bit l);
        result_t r;
        r.node = node[5:0];
        r.dsq = dsq;
        r.found = f;
        r.ovf = o;
        r.last = l;
        return r;
    endfunction

    task automatic add_expected(result_t r);
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic predict_command(cmd_item_t it);
        logic signed [15:0] q [7];
        logic [33:0] d;
        logic [33:0] best_d;
        int best;
        int n;
        int e;
        for (int j = 0; j < 7; j++) q[j] = it.joints[j];
        case (it.cmd)
            jsns_pkg::CMD_APPEND: begin
                if (stored_count >= DEPTH) begin
                    add_expected(mk(0, 0, 0, 1, 1));
                end else begin
                    stored_joints[stored_count] = q;
                    add_expected(mk(stored_count, 0, 1, 0, 1));
                    stored_count++;
                end
            end
            jsns_pkg::CMD_NEAREST: begin
                if (stored_count == 0) begin
                    add_expected(mk(0, 0, 0, 0, 1));
                end else begin
                    best = 0;
                    best_d = 0;
                    for (int i = 0; i < stored_count; i++) begin
                        d = joint_distance(stored_joints[i], q);
                        if (i == 0 || d < best_d) begin
                            best = i;
                            best_d = d;
                        end
                    end
                    add_expected(mk(best, best_d, 1, 0, 1));
                end
            end
            jsns_pkg::CMD_NEIGHBORS: begin
                n = 0;
                e = it.entry_index;
                if (e < stored_count) begin
                    for (int i = 0; i < stored_count; i++) begin
                        if (i != e) begin
                            d = joint_distance(stored_joints[e], stored_joints[i]);
                            if (d <= neighbor_limit) begin
                                add_expected(mk(i, d, 1, 0, 0));
                                n++;
                            end
                        end
                    end
                end
                if (n == 0) add_expected(mk(0, 0, 0, 0, 1));
                else pending_results[$].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result checker
    always @(posedge aclk) begin
        result_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction", m_tdata[5:0], 0);
            end else begin
                w = pending_results.pop_front();
                if (m_tdata[5:0] !== w.node) report_mismatch("node_index", m_tdata[5:0], w.node);
                if (m_tdata[39:6] !== w.dsq)
                    report_mismatch("distance_squared", m_tdata[39:6], w.dsq);
                if (m_tuser[0] !== w.found) report_mismatch("found", m_tuser[0], w.found);
                if (m_tuser[1] !== w.ovf) report_mismatch("overflow", m_tuser[1], w.ovf);
                if (m_tlast !== w.last) report_mismatch("last", m_tlast, w.last);
            end
        end
    end

    // receiver ready
    initial begin
        int cnt;
        cnt = 0;
        forever begin
            @(negedge aclk);
            cnt++;
            if (hold_off) m_tready <= 1'b0;
            else if (calm_rx || (cnt % 3000) < 600) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(99) >= 6);
        end
    end

    // returns right after the accepting edge; s_tvalid is dropped by the
    // next call or by drain_results at the following falling edge
    task automatic send_command(cmd_item_t it, bit random_gap);
        @(negedge aclk);
        if (random_gap) begin
            while ($urandom_range(99) < 6) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tuser <= it.cmd;
        s_tdata <= {2'b00, it.joints, it.entry_index};
        s_tvalid <= 1'b1;
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        predict_command(it);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (120) @(negedge aclk);
    endtask

    task automatic write_limit(logic [33:0] v);
        drain_results();
        cfg_wr_data <= v;
        cfg_wr_en <= 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        neighbor_limit = v;
    endtask

    function automatic cmd_item_t pick_item(int cmd, int spread);
        cmd_item_t it;
        it.cmd = cmd[1:0];
        it.entry_index = 6'($urandom_range(63));
        for (int j = 0; j < 7; j++) begin
            if (spread == 0) it.joints[j] = 16'($urandom);
            else it.joints[j] = 16'($urandom_range(2 * spread) - spread);
        end
        return it;
    endfunction

    initial begin
        table_row_t rows[$];
        table_row_t r;
        cmd_item_t it;
        int k;
        int sp;
        neighbor_limit = 0;
        stored_count = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table
        r.known = 1;
        r.item = '{jsns_pkg::CMD_NEAREST, 6'd0, '0}; r.res = mk(0, 0, 0, 0, 1);
        rows.insert(rows.size(), r);
        r.item = '{jsns_pkg::CMD_NEIGHBORS, 6'd0, '0}; r.res = mk(0, 0, 0, 0, 1);
        rows.insert(rows.size(), r);
        r.item = '{jsns_pkg::CMD_APPEND, 6'd63, {7{16'h8000}}}; r.res = mk(0, 0, 1, 0, 1);
        rows.insert(rows.size(), r);
        r.item = '{jsns_pkg::CMD_APPEND, 6'd0, {7{16'h7fff}}}; r.res = mk(1, 0, 1, 0, 1);
        rows.insert(rows.size(), r);
        r.item = '{jsns_pkg::CMD_APPEND, 6'd0, '0}; r.res = mk(2, 0, 1, 0, 1);
        rows.insert(rows.size(), r);
        r.item = '{jsns_pkg::CMD_APPEND, 6'd0, '0}; r.res = mk(3, 0, 1, 0, 1);
        rows.insert(rows.size(), r);
        r.item = '{jsns_pkg::CMD_NEAREST, 6'd0, {7{16'h8000}}}; r.res = mk(0, 0, 1, 0, 1);
        rows.insert(rows.size(), r);
        r.item = '{jsns_pkg::CMD_NEAREST, 6'd0, '0}; r.res = mk(2, 0, 1, 0, 1);
        rows.insert(rows.size(), r);
        r.item = '{jsns_pkg::CMD_NEIGHBORS, 6'd2, '0}; r.res = mk(3, 0, 1, 0, 1);
        rows.insert(rows.size(), r);
        r.item = '{jsns_pkg::CMD_NEIGHBORS, 6'd63, '0}; r.res = mk(0, 0, 0, 0, 1);
        rows.insert(rows.size(), r);
        r.known = 0;
        r.item = '{jsns_pkg::CMD_NEAREST, 6'd0, {7{16'h7fff}}};
        rows.insert(rows.size(), r);
        r.item = '{2'(CMD_UNDEF), 6'd5, {7{16'h1234}}};
        rows.insert(rows.size(), r);
        r.item = '{jsns_pkg::CMD_NEIGHBORS, 6'd0, '0};
        rows.insert(rows.size(), r);
        foreach (rows[i]) begin
            send_command(rows[i].item, 0);
            if (rows[i].known) begin
                k = pending_results.size() - 1;
                if (pending_results[k].node !== rows[i].res.node ||
                    pending_results[k].dsq !== rows[i].res.dsq ||
                    pending_results[k].found !== rows[i].res.found)
                    report_mismatch("directed row", i, 0);
            end
        end
        write_limit(34'h3_FFFF_FFFF);
        it = '{jsns_pkg::CMD_NEIGHBORS, 6'd1, '0};
        send_command(it, 0);
        it = '{jsns_pkg::CMD_NEIGHBORS, 6'd0, '0};
        send_command(it, 0);

        // random traffic, mostly clustered states so neighbor lists are real
        for (int n = 0; n < 430; n++) begin
            if (n % 100 == 50) begin
                drain_results();
                case (n / 100)
                    0: write_limit(0);
                    1: write_limit(34'($urandom_range(200000, 20000000)));
                    2: write_limit(34'h3_FFFF_FFFF);
                    default: write_limit({$urandom, 2'($urandom)});
                endcase
            end
            if (n == 150) begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (400) @(negedge aclk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            sp = ($urandom_range(3) == 0) ? 0 : 3000;
            k = $urandom_range(99);
            if (k < 35) it = pick_item(jsns_pkg::CMD_APPEND, sp);
            else if (k < 60) it = pick_item(jsns_pkg::CMD_NEAREST, sp);
            else if (k < 97) begin
                it = pick_item(jsns_pkg::CMD_NEIGHBORS, sp);
                if (stored_count != 0 && k < 92)
                    it.entry_index = 6'($urandom_range(stored_count - 1));
            end else it = pick_item(CMD_UNDEF, sp);
            send_command(it, n < 300 || n > 380);
        end
        it = pick_item(jsns_pkg::CMD_APPEND, 0);
        send_command(it, 1);
        @(negedge aclk);
        s_tvalid <= 1'b0;

        calm_rx = 1'b1;
        k = 0;
        while (pending_results.size() != 0 && k < 100000) begin
            @(negedge aclk);
            k++;
        end
        repeat (150) @(negedge aclk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
